/* hdl/lpoh_pkg.sv */
package lpoh_pkg;

	// Field and register widths
	localparam int RANGE_W   = 13;
	localparam int CS_W      = 11;
	localparam int BEAR_W    = 9;
	localparam int COUNT_W   = 9;
	localparam int CELL_W    = 7;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 2'd1;

	// Register reset values
	localparam logic [RANGE_W-1:0] RANGE_LIMIT_RST = 13'd2560;
	localparam logic [CS_W-1:0]    CELL_SIZE_RST   = 11'd64;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

	// pi in Q30
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef struct packed {
		logic signed [BEAR_W-1:0] bearing_deg;
		logic [RANGE_W-1:0]       range_q8;
		logic                     scan_start;
	} lpoh_item_t;

	typedef struct packed {
		logic               hit;
		logic               out_of_grid;
		logic [CELL_W-1:0]  cell_x;
		logic [CELL_W-1:0]  cell_y;
		logic [COUNT_W-1:0] cell_count;
		logic [COUNT_W-1:0] scan_max;
	} lpoh_result_t;

	// sin(k deg) in Q30 by an eleven-term integer Taylor series, elaboration only
	function automatic logic [63:0] sine_q30(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
		term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
		term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
		term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
		term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
		term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
		term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
		term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
		term = ((term * x2) >> 30) / 64'd342; sum = sum - term;
		term = ((term * x2) >> 30) / 64'd420; sum = sum + term;
		return sum;
	endfunction

endpackage

/* hdl/lpoh_count_ram.sv */
module lpoh_count_ram import lpoh_pkg::*; #(
	parameter int DEPTH = 6400,
	parameter int AW    = 13
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [COUNT_W-1:0] wdata,
	input  logic [AW-1:0]      raddr,
	output logic [COUNT_W-1:0] rdata
);

	logic [COUNT_W-1:0] mem [DEPTH];
	logic [COUNT_W-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/lidar_polar_occupancy_histogram.sv */
// Polar lidar occupancy histogram. Pulse start with a return while busy is low; the
// result appears on result for exactly one cycle with done high and must be taken then.
// A return beyond range_limit finishes at the range check; a full grid lookup runs the
// quadrant and table steps, then for the column and then the row a multiply, the in-grid
// compare and one quotient bit per cycle of the divide, both on the shared subtractor, then
// a read-modify-write of the count memory. A return with scan_start set first sweeps all
// GRID_SIDE*GRID_SIDE entries (6400 by default) of the count memory, one entry per cycle.
// The same sweep runs after reset, with busy high, before the first return
// is taken; configuration writes are taken at any time.
module lidar_polar_occupancy_histogram import lpoh_pkg::*; #(
	parameter int GRID_SIDE      = 80,
	parameter int TRIG_FRAC_BITS = 15
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  lpoh_item_t           item,
	output logic                 busy,
	output logic                 done,
	output lpoh_result_t         result,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
	localparam int AW     = $clog2(DEPTH);
	localparam int QW     = $clog2(GRID_SIDE);
	localparam int QCW    = $clog2(QW + 1);
	localparam int GCS_W  = CS_W + $clog2(GRID_SIDE + 1);
	localparam int UW     = GCS_W + 1;
	localparam int SNW    = UW + 1;
	localparam int TW     = TRIG_FRAC_BITS + 2;
	localparam int PW     = RANGE_W + 1 + TW;
	localparam int RND_SH = 30 - TRIG_FRAC_BITS;

	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

	localparam logic [8:0] ANG_90  = 9'd90;
	localparam logic [8:0] ANG_180 = 9'd180;
	localparam logic [8:0] ANG_270 = 9'd270;
	localparam logic [9:0] ANG_360 = 10'd360;

	// Sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_ANG  = 4'd2;
	localparam logic [3:0] S_TRIG = 4'd3;
	localparam logic [3:0] S_MUL  = 4'd4;
	localparam logic [3:0] S_CMP  = 4'd5;
	localparam logic [3:0] S_DIV  = 4'd6;
	localparam logic [3:0] S_ADDR = 4'd7;
	localparam logic [3:0] S_RD   = 4'd8;
	localparam logic [3:0] S_WR   = 4'd9;

	// Quarter-wave sine table at the output precision
	typedef logic [TRIG_FRAC_BITS:0] sin_tab_t [0:90];

	function automatic sin_tab_t build_sin_tab();
		sin_tab_t tab;
		for (int k = 0; k <= 90; k++) begin
			tab[k] = (TRIG_FRAC_BITS + 1)'((sine_q30(k) + (64'd1 << (RND_SH - 1))) >> RND_SH);
		end
		return tab;
	endfunction

	localparam sin_tab_t SIN_TAB = build_sin_tab();

	logic [3:0]          state_q;
	logic [RANGE_W-1:0]  range_limit_q;
	logic [CS_W-1:0]     cell_size_q;
	logic                item_pend_q;
	logic [AW-1:0]       clr_q;
	logic [COUNT_W-1:0]  max_q;
	logic                axis_q;
	logic [QCW-1:0]      cnt_q;
	logic                done_q;

	logic signed [BEAR_W-1:0] bearing_q;
	logic [RANGE_W-1:0]  range_q;
	logic [CS_W-1:0]     cs_q;
	logic [GCS_W-1:0]    gcs_q;
	logic [GCS_W-1:0]    off_q;
	logic [1:0]          quad_q;
	logic [6:0]          r_q;
	logic signed [TW-1:0] sin_q;
	logic signed [TW-1:0] cos_q;
	logic signed [SNW-1:0] num_q;
	logic [UW-1:0]       rem_q;
	logic [UW-1:0]       div_q;
	logic [QW-1:0]       quo_q;
	logic [QW-1:0]       cx_q;
	logic [QW-1:0]       cy_q;
	logic [AW-1:0]       addr_q;
	lpoh_result_t        res_q;

	logic                accept;
	logic [CS_W-1:0]     cs_eff;
	logic signed [9:0]   ang_s;
	logic [8:0]          ang_u;
	logic [TRIG_FRAC_BITS:0] t_r;
	logic [TRIG_FRAC_BITS:0] t_c;
	logic signed [TW-1:0] t_r_s;
	logic signed [TW-1:0] t_c_s;
	logic signed [TW-1:0] mul_op;
	logic signed [PW-1:0] prod;
	logic signed [SNW-1:0] num_d;
	logic [UW-1:0]       sub_a;
	logic [UW-1:0]       sub_b;
	logic [UW:0]         diff;
	logic                borrow;
	logic [QW-1:0]       quo_d;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [COUNT_W-1:0]  ram_wdata;
	logic [COUNT_W-1:0]  ram_rdata;
	logic [COUNT_W-1:0]  cnt_new;

	assign accept = start && (state_q == S_IDLE);
	assign cs_eff = (cell_size_q == '0) ? CS_W'(1) : cell_size_q;

	// Bearing reduced to 0..359
	assign ang_s = 10'(bearing_q) + ((bearing_q < 0) ? $signed(ANG_360) : 10'sd0);
	assign ang_u = ang_s[8:0];

	// Table reads for the current quadrant offset
	assign t_r   = SIN_TAB[r_q];
	assign t_c   = SIN_TAB[7'd90 - r_q];
	assign t_r_s = $signed({1'b0, t_r});
	assign t_c_s = $signed({1'b0, t_c});

	// Shared multiplier: range times cosine, then sine
	assign mul_op = axis_q ? sin_q : cos_q;
	assign prod   = $signed({1'b0, range_q}) * mul_op;
	assign num_d  = SNW'(prod >>> TRIG_FRAC_BITS) + $signed(SNW'(off_q));

	// Shared subtractor: grid bound compare, then restoring divide steps
	always_comb begin
		sub_a = rem_q;
		sub_b = div_q;
		if (state_q == S_CMP) begin
			sub_a = UW'(num_q);
			sub_b = UW'(gcs_q);
		end
	end

	assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow = diff[UW];
	assign quo_d  = QW'({quo_q, ~borrow});

	// Saturating increment of the read count
	assign cnt_new = (ram_rdata == COUNT_MAX) ? COUNT_MAX : ram_rdata + COUNT_W'(1);

	// Count memory write port: clear sweep or increment
	assign ram_we    = (state_q == S_CLR) || (state_q == S_WR);
	assign ram_waddr = (state_q == S_CLR) ? clr_q : addr_q;
	assign ram_wdata = (state_q == S_CLR) ? '0 : cnt_new;

	lpoh_count_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_limit_q <= RANGE_LIMIT_RST;
			cell_size_q   <= CELL_SIZE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_RANGE_LIMIT: range_limit_q <= cfg_data[RANGE_W-1:0];
				REG_CELL_SIZE:   cell_size_q   <= cfg_data[CS_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			item_pend_q <= 1'b0;
			clr_q       <= '0;
			max_q       <= COUNT_W'(1);
			axis_q      <= 1'b0;
			cnt_q       <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						item_pend_q <= 1'b1;
						state_q     <= item.scan_start ? S_CLR : S_ANG;
					end
				end
				S_CLR: begin
					if (clr_q == CLR_LAST) begin
						clr_q   <= '0;
						max_q   <= COUNT_W'(1);
						state_q <= item_pend_q ? S_ANG : S_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_ANG: begin
					axis_q <= 1'b0;
					if (range_q > range_limit_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_TRIG;
					end
				end
				S_TRIG: state_q <= S_MUL;
				S_MUL:  state_q <= S_CMP;
				S_CMP: begin
					cnt_q <= QCW'(QW - 1);
					if (num_q[SNW-1] || !borrow) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - QCW'(1);
					if (cnt_q == '0) begin
						axis_q  <= 1'b1;
						state_q <= axis_q ? S_ADDR : S_MUL;
					end
				end
				S_ADDR: state_q <= S_RD;
				S_RD:   state_q <= S_WR;
				S_WR: begin
					if (cnt_new > max_q) begin
						max_q <= cnt_new;
					end
					item_pend_q <= 1'b0;
					done_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_ANG && range_q > range_limit_q) begin
				item_pend_q <= 1'b0;
			end
			if (state_q == S_CMP && (num_q[SNW-1] || !borrow)) begin
				item_pend_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			bearing_q <= item.bearing_deg;
			range_q   <= item.range_q8;
			cs_q      <= cs_eff;
			gcs_q     <= GCS_W'(GCS_W'(cs_eff) * GCS_W'(GRID_SIDE));
			off_q     <= GCS_W'(GCS_W'(cs_eff) * GCS_W'(GRID_SIDE / 2));
		end

		// Quadrant and offset within it
		if (state_q == S_ANG) begin
			if (ang_u < ANG_90) begin
				quad_q <= 2'd0;
				r_q    <= 7'(ang_u);
			end else if (ang_u < ANG_180) begin
				quad_q <= 2'd1;
				r_q    <= 7'(ang_u - ANG_90);
			end else if (ang_u < ANG_270) begin
				quad_q <= 2'd2;
				r_q    <= 7'(ang_u - ANG_180);
			end else begin
				quad_q <= 2'd3;
				r_q    <= 7'(ang_u - ANG_270);
			end
		end

		// Signed sine and cosine by quadrant symmetry
		if (state_q == S_TRIG) begin
			unique case (quad_q)
				2'd0: begin sin_q <= t_r_s;  cos_q <= t_c_s;  end
				2'd1: begin sin_q <= t_c_s;  cos_q <= -t_r_s; end
				2'd2: begin sin_q <= -t_r_s; cos_q <= -t_c_s; end
				2'd3: begin sin_q <= -t_c_s; cos_q <= t_r_s;  end
			endcase
		end

		if (state_q == S_MUL) begin
			num_q <= num_d;
		end

		if (state_q == S_CMP) begin
			rem_q <= UW'(num_q);
			div_q <= UW'(cs_q) << (QW - 1);
			quo_q <= '0;
		end

		// One quotient bit per cycle
		if (state_q == S_DIV) begin
			if (!borrow) begin
				rem_q <= diff[UW-1:0];
			end
			div_q <= div_q >> 1;
			quo_q <= quo_d;
			if (cnt_q == '0) begin
				if (axis_q) begin
					cy_q <= quo_d;
				end else begin
					cx_q <= quo_d;
				end
			end
		end

		if (state_q == S_ADDR) begin
			addr_q <= AW'(AW'(cy_q) * AW'(GRID_SIDE) + AW'(cx_q));
		end

		// Result register
		if (state_q == S_ANG && range_q > range_limit_q) begin
			res_q.hit         <= 1'b0;
			res_q.out_of_grid <= 1'b0;
			res_q.cell_x      <= '0;
			res_q.cell_y      <= '0;
			res_q.cell_count  <= '0;
			res_q.scan_max    <= max_q;
		end
		if (state_q == S_CMP && (num_q[SNW-1] || !borrow)) begin
			res_q.hit         <= 1'b0;
			res_q.out_of_grid <= 1'b1;
			res_q.cell_x      <= '0;
			res_q.cell_y      <= '0;
			res_q.cell_count  <= '0;
			res_q.scan_max    <= max_q;
		end
		if (state_q == S_WR) begin
			res_q.hit         <= 1'b1;
			res_q.out_of_grid <= 1'b0;
			res_q.cell_x      <= CELL_W'(cx_q);
			res_q.cell_y      <= CELL_W'(cy_q);
			res_q.cell_count  <= cnt_new;
			res_q.scan_max    <= (cnt_new > max_q) ? cnt_new : max_q;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

/* hdl/lpoh_checker.sv */
module lpoh_checker import lpoh_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         start,
	input logic         busy,
	input logic         done,
	input lpoh_result_t result
);

	// A result strobe leaves the block ready for the next transfer
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// An accepted return keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("not busy after accepted return");

	// A counted point is never also off the grid, and the maximum covers it
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hit) |-> (!result.out_of_grid && result.cell_count != 0
			&& result.scan_max >= result.cell_count))
		else $error("inconsistent hit result");

	// Without a hit the cell fields are zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.cell_x == 0 && result.cell_y == 0
			&& result.cell_count == 0))
		else $error("nonzero cell fields without hit");

	// The scan maximum never drops below one
	a_max_floor: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.scan_max != 0))
		else $error("scan maximum is zero");

endmodule

bind lidar_polar_occupancy_histogram lpoh_checker u_lpoh_checker (.*);
